/* hdl/canonical_huffman_table_decoder_top_defines.svh */
// Assertion macros for the canonical Huffman table decoder checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef CANONICAL_HUFFMAN_TABLE_DECODER_TOP_DEFINES_SVH
`define CANONICAL_HUFFMAN_TABLE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CHTD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chtd: assertion failed");

// Next-cycle implication, disabled during reset.
`define CHTD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chtd: assertion failed");

`endif

/* hdl/chtd_pkg.sv */
// Shared types and constants for the canonical Huffman table decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package chtd_pkg;

    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int MAX_SYMBOLS_DEF  = 256;

    localparam int DATA_W   = 8;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 5;
    localparam int TB_W     = 9;
    localparam int CODE_W   = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_SYMBOL   = 3'd0,
        ST_LOADED   = 3'd1,
        ST_TOO_MANY = 3'd2,
        ST_OVERSUB  = 3'd3,
        ST_INVALID  = 3'd4,
        ST_NO_TABLE = 3'd5
    } status_t;

    // Control from the table loader to the decoder
    typedef struct packed {
        logic            restart;     // new table started: drop table and partial code
        logic            table_done;  // table now usable: set ready, clear partial code
        logic            result;      // this table byte produces a result
        status_t         status;
        logic [TB_W-1:0] table_bytes;
    } load_evt_t;

endpackage

`default_nettype wire

/* hdl/chtd_channels.sv */
// Valid/ready channel interfaces for table bytes or code bits in, results out.
// Depends on chtd_pkg for field widths.
`default_nettype none

interface chtd_in_if import chtd_pkg::*;;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [DATA_W-1:0] data;
    logic              first;

    modport source (output valid, output kind, output data, output first, input ready);
    modport sink   (input valid, input kind, input data, input first, output ready);
endinterface

interface chtd_out_if import chtd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   symbol;
    logic [LEN_W-1:0]    code_length;
    logic [TB_W-1:0]     table_bytes;

    modport source (output valid, output status, output symbol, output code_length,
                    output table_bytes, input ready);
    modport sink   (input valid, input status, input symbol, input code_length,
                    input table_bytes, output ready);
endinterface

`default_nettype wire

/* hdl/chtd_loader.sv */
// Table loader: per-length counts, running totals, oversubscription check.
// Depends on chtd_pkg; drives the write port of the symbol memory in the top level.
`default_nettype none

module chtd_loader import chtd_pkg::*; #(
    parameter  int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter  int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
    localparam int SI_W         = $clog2(MAX_SYMBOLS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_fire,
    input  wire logic [DATA_W-1:0] byte_data,
    input  wire logic              byte_first,
    output logic [DATA_W-1:0]      length_counts [MAX_CODE_LEN],
    output logic [LEN_W-1:0]       longest_length,
    output load_evt_t              evt,
    output logic                   wr_en,
    output logic [SI_W-1:0]        wr_addr,
    output logic [DATA_W-1:0]      wr_data
);

    localparam int LI_W = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam logic [TB_W-1:0] LEN_C  = TB_W'(MAX_CODE_LEN);
    localparam logic [TB_W:0]   SYMS_C = (TB_W+1)'(MAX_SYMBOLS);
    localparam logic [TB_W-1:0] SAT_C  = {TB_W{1'b1}};

    logic [DATA_W-1:0] lc_reg [MAX_CODE_LEN];
    logic [TB_W-1:0]   bytes_loaded_reg, bytes_loaded_next;
    logic [TB_W-1:0]   total_codes_reg, total_codes_next;
    logic [16:0]       free_slots_reg, free_slots_next;
    logic              oversub_reg, oversub_next;
    logic [LEN_W-1:0]  longest_reg, longest_next;

    logic              active;
    logic              count_phase;
    logic [TB_W-1:0]   bl;
    logic [TB_W-1:0]   tc;
    logic [16:0]       fs;
    logic              ov;
    logic [TB_W:0]     tc_sum;
    logic [TB_W-1:0]   sidx;
    logic [16:0]       fs_diff;

    // Pick the starting point: a first byte restarts from the reset values
    always_comb
    begin
        active = byte_first || (bytes_loaded_reg != '0);
        bl     = byte_first ? '0 : bytes_loaded_reg;
        tc     = byte_first ? '0 : total_codes_reg;
        fs     = byte_first ? 17'd2 : free_slots_reg;
        ov     = byte_first ? 1'b0 : oversub_reg;
        count_phase = (bl < LEN_C);
        tc_sum  = {1'b0, tc} + {{(TB_W+1-DATA_W){1'b0}}, byte_data};
        fs_diff = fs - {{(17-DATA_W){1'b0}}, byte_data};
        sidx    = bl - LEN_C;
    end

    // Next state and result of one table byte
    always_comb
    begin
        bytes_loaded_next = bl + 1'b1;
        total_codes_next  = tc;
        free_slots_next   = fs;
        oversub_next      = ov;
        longest_next      = byte_first ? '0 : longest_reg;
        evt               = '0;
        evt.status        = ST_LOADED;
        evt.restart       = byte_fire && byte_first;
        wr_en             = 1'b0;
        wr_addr           = sidx[SI_W-1:0];
        wr_data           = byte_data;

        if (count_phase)
        begin
            total_codes_next = (tc_sum > {1'b0, SAT_C}) ? SAT_C : tc_sum[TB_W-1:0];
            if (byte_data != '0)
            begin
                longest_next = LEN_W'(bl) + 1'b1;
            end
            // Advance the code-space check one length
            if (!ov)
            begin
                if ({{(17-DATA_W){1'b0}}, byte_data} > fs)
                begin
                    oversub_next    = 1'b1;
                    free_slots_next = '0;
                end
                else if (bl < LEN_C - 1'b1)
                begin
                    free_slots_next = {fs_diff[15:0], 1'b0};
                end
                else
                begin
                    free_slots_next = fs_diff;
                end
            end
            // Close the count section
            if (bl == LEN_C - 1'b1)
            begin
                if ({1'b0, total_codes_next} > SYMS_C)
                begin
                    bytes_loaded_next = '0;
                    evt.result        = byte_fire;
                    evt.status        = ST_TOO_MANY;
                end
                else if (oversub_next)
                begin
                    bytes_loaded_next = '0;
                    evt.result        = byte_fire;
                    evt.status        = ST_OVERSUB;
                end
                else if (total_codes_next == '0)
                begin
                    bytes_loaded_next = '0;
                    evt.result        = byte_fire;
                    evt.table_done    = byte_fire;
                    evt.status        = ST_LOADED;
                    evt.table_bytes   = LEN_C;
                end
            end
        end
        else
        begin
            // Store one symbol in canonical order
            wr_en = byte_fire && active && ({1'b0, sidx} < SYMS_C);
            if ({1'b0, sidx} + 1'b1 >= {1'b0, tc})
            begin
                bytes_loaded_next = '0;
                evt.result        = byte_fire && active;
                evt.table_done    = byte_fire && active;
                evt.status        = ST_LOADED;
                evt.table_bytes   = bl + 1'b1;
            end
        end

        if (!active)
        begin
            evt.result     = 1'b0;
            evt.table_done = 1'b0;
        end
    end

    // Hold load progress; update only on a table byte transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_loaded_reg <= '0;
            total_codes_reg  <= '0;
            free_slots_reg   <= 17'd2;
            oversub_reg      <= 1'b0;
            longest_reg      <= '0;
            for (int i = 0; i < MAX_CODE_LEN; i++)
            begin
                lc_reg[i] <= '0;
            end
        end
        else if (byte_fire && active)
        begin
            bytes_loaded_reg <= bytes_loaded_next;
            total_codes_reg  <= total_codes_next;
            free_slots_reg   <= free_slots_next;
            oversub_reg      <= oversub_next;
            longest_reg      <= longest_next;
            if (count_phase)
            begin
                lc_reg[bl[LI_W-1:0]] <= byte_data;
            end
        end
    end

    assign length_counts  = lc_reg;
    assign longest_length = longest_reg;

endmodule

`default_nettype wire

/* hdl/canonical_huffman_table_decoder_top.sv */
// Top level of the canonical Huffman table decoder: bit-serial decode and symbol memory.
// Depends on chtd_pkg, chtd_channels and chtd_loader.
//
//  channel  | dir | contents
//  ---------+-----+--------------------------------------------------
//  items    | in  | kind, data, first: table byte or one code bit
//  results  | out | status, symbol, code_length, table_bytes
//
// One item per cycle while items.ready is high; a result appears in the cycle after its transfer.
// The symbol lookup is one read of the symbol memory, registered with the result.
// items.ready drops only while a result waits and results.ready is low.
// After reset no table is loaded; the symbol memory needs no clearing pass.
`default_nettype none

module canonical_huffman_table_decoder_top import chtd_pkg::*; #(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    chtd_in_if.sink    items,
    chtd_out_if.source results
);

    localparam int LI_W = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam int SI_W = $clog2(MAX_SYMBOLS);
    localparam logic [LEN_W-1:0] LEN_C  = LEN_W'(MAX_CODE_LEN);
    localparam logic [9:0]       SYMS_C = 10'(MAX_SYMBOLS);

    logic              fire;
    logic              byte_fire;
    logic              bit_fire;

    logic [DATA_W-1:0] length_counts [MAX_CODE_LEN];
    logic [LEN_W-1:0]  longest_length;
    load_evt_t         evt;
    logic              wr_en;
    logic [SI_W-1:0]   wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic              table_ready_reg;
    logic [CODE_W-1:0] code_accum_reg;
    logic [16:0]       first_code_reg;
    logic [8:0]        symbol_base_reg;
    logic [LEN_W-1:0]  bits_taken_reg;

    logic [DATA_W-1:0] sym_mem [MAX_SYMBOLS];
    logic [DATA_W-1:0] rd_data_reg;

    logic              out_valid_reg;
    status_t           status_reg;
    logic              sym_sel_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [TB_W-1:0]   tb_reg;

    logic [LEN_W-1:0]  n;
    logic [CODE_W-1:0] code;
    logic [DATA_W-1:0] cnt;
    logic [16:0]       diff;
    logic              hit;
    logic              give_up;
    logic [9:0]        idx;
    logic              sym_ok;
    logic              rd_en;

    // Transfer on both sides
    assign items.ready = !out_valid_reg || results.ready;
    assign fire        = items.valid && items.ready;
    assign byte_fire   = fire && !items.kind;
    assign bit_fire    = fire && items.kind;

    chtd_loader #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .MAX_SYMBOLS  (MAX_SYMBOLS)
    ) u_loader (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_fire      (byte_fire),
        .byte_data      (items.data),
        .byte_first     (items.first),
        .length_counts  (length_counts),
        .longest_length (longest_length),
        .evt            (evt),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data)
    );

    // Test one more code bit against the current length
    always_comb
    begin
        n       = bits_taken_reg + 1'b1;
        code    = {code_accum_reg[CODE_W-2:0], items.data[0]};
        cnt     = length_counts[bits_taken_reg[LI_W-1:0]];
        diff    = {1'b0, code} - first_code_reg;
        hit     = ({1'b0, code} >= first_code_reg) && (diff < {9'b0, cnt});
        give_up = (n >= longest_length) || (n >= LEN_C);
        idx     = {1'b0, symbol_base_reg} + {2'b0, diff[DATA_W-1:0]};
        sym_ok  = (idx < SYMS_C);
        rd_en   = bit_fire && table_ready_reg && hit && sym_ok;
    end

    // Symbol memory: one write port from the loader, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sym_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= sym_mem[idx[SI_W-1:0]];
        end
    end

    // Decode state: restart on a new table, clear on a finished code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_ready_reg <= 1'b0;
            code_accum_reg  <= '0;
            first_code_reg  <= '0;
            symbol_base_reg <= '0;
            bits_taken_reg  <= '0;
        end
        else if (evt.restart || evt.table_done)
        begin
            table_ready_reg <= evt.table_done;
            code_accum_reg  <= '0;
            first_code_reg  <= '0;
            symbol_base_reg <= '0;
            bits_taken_reg  <= '0;
        end
        else if (bit_fire && table_ready_reg)
        begin
            if (hit || give_up)
            begin
                code_accum_reg  <= '0;
                first_code_reg  <= '0;
                symbol_base_reg <= '0;
                bits_taken_reg  <= '0;
            end
            else
            begin
                code_accum_reg  <= code;
                first_code_reg  <= {first_code_reg[15:0] + {8'b0, cnt}, 1'b0};
                symbol_base_reg <= symbol_base_reg + {1'b0, cnt};
                bits_taken_reg  <= n;
            end
        end
    end

    // Output register: load a result on transfer, drop it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (byte_fire && evt.result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (bit_fire && (!table_ready_reg || hit || give_up))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_fire)
        begin
            status_reg  <= evt.status;
            sym_sel_reg <= 1'b0;
            len_reg     <= '0;
            tb_reg      <= evt.table_bytes;
        end
        else if (bit_fire)
        begin
            tb_reg      <= '0;
            sym_sel_reg <= table_ready_reg && hit && sym_ok;
            if (!table_ready_reg)
            begin
                status_reg <= ST_NO_TABLE;
                len_reg    <= '0;
            end
            else if (hit)
            begin
                status_reg <= ST_SYMBOL;
                len_reg    <= n;
            end
            else
            begin
                status_reg <= ST_INVALID;
                len_reg    <= n;
            end
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.status      = status_reg;
    assign results.symbol      = sym_sel_reg ? rd_data_reg : '0;
    assign results.code_length = len_reg;
    assign results.table_bytes = tb_reg;

endmodule

`default_nettype wire

/* hdl/chtd_checker.sv */
// Port-level checks for the canonical Huffman table decoder, bound to the top level.
// Depends on chtd_pkg and canonical_huffman_table_decoder_top_defines.svh.
`default_nettype none
`include "canonical_huffman_table_decoder_top_defines.svh"

module chtd_checker import chtd_pkg::*; #(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                items_ready,
    input wire logic                results_valid,
    input wire logic                results_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [DATA_W-1:0]   symbol,
    input wire logic [LEN_W-1:0]    code_length,
    input wire logic [TB_W-1:0]     table_bytes
);

    // Hold a stalled result
    `CHTD_ASSERT_NXT(a_hold, results_valid && !results_ready, results_valid && $stable({status, symbol, code_length, table_bytes}))

    // Take no item while a result waits on a stalled sink
    `CHTD_ASSERT_IMP(a_backpressure, results_valid && !results_ready, !items_ready)

    // A code result carries a length in range
    `CHTD_ASSERT_IMP(a_len, results_valid && (status == ST_SYMBOL || status == ST_INVALID), code_length != '0 && code_length <= LEN_W'(MAX_CODE_LEN))

    // A loaded table reports a plausible byte count and nothing else
    `CHTD_ASSERT_IMP(a_tb, results_valid && status == ST_LOADED, table_bytes >= TB_W'(MAX_CODE_LEN) && table_bytes <= TB_W'(MAX_CODE_LEN + MAX_SYMBOLS) && code_length == '0 && symbol == '0)

endmodule

bind canonical_huffman_table_decoder_top chtd_checker #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .MAX_SYMBOLS  (MAX_SYMBOLS)
) u_chtd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .items_ready   (items.ready),
    .results_valid (results.valid),
    .results_ready (results.ready),
    .status        (results.status),
    .symbol        (results.symbol),
    .code_length   (results.code_length),
    .table_bytes   (results.table_bytes)
);

`default_nettype wire

/* test/tb_canonical_huffman_table_decoder_top.sv */
// Testbench for canonical_huffman_table_decoder_top: table loads and bit-serial decode.
// Checks every result against a built-in prediction of the decoder state.
// Depends on chtd_pkg, chtd_channels and the decoder RTL.

module tb_canonical_huffman_table_decoder_top;
    import chtd_pkg::*;

    localparam bit KIND_TABLE   = 1'b0;
    localparam bit KIND_BIT     = 1'b1;
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES  = 300;
    localparam int CLK_HALF     = 4;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] symbol;
        logic [LEN_W-1:0]  code_length;
        logic [TB_W-1:0]   table_bytes;
    } huff_report_t;

    typedef enum int {SINK_OPEN, SINK_MOSTLY, SINK_SPARSE, SINK_THIRDS} sink_mode_t;

    // Tracks the loaded table and the partial code, queues the reports they cause
    class huffman_scoreboard;
        logic [DATA_W-1:0] len_count [MAX_CODE_LEN_DEF];
        logic [DATA_W-1:0] sym_mem [MAX_SYMBOLS_DEF];
        int unsigned       load_pos;
        int unsigned       code_total;
        int unsigned       longest;
        int unsigned       bits_in;
        int unsigned       accum;
        int unsigned       first_code;
        int unsigned       sym_base;
        bit                have_table;
        huff_report_t      due_reports [$];
        int unsigned       error_count;

        function new();
            foreach (len_count[i])
                len_count[i] = '0;
            load_pos    = 0;
            code_total  = 0;
            longest     = 0;
            have_table  = 1'b0;
            error_count = 0;
            clear_partial();
        endfunction

        function void clear_partial();
            accum      = 0;
            first_code = 0;
            sym_base   = 0;
            bits_in    = 0;
        endfunction

        function bit loading();
            return load_pos != 0;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // Advance the state by one item; return 1 when it yields a report
        function bit predict_report(bit kind, logic [DATA_W-1:0] data, bit start,
                                    output huff_report_t rpt);
            int unsigned n;
            int unsigned cnt;
            int unsigned code;
            int unsigned room;
            int unsigned pos;
            int          l;
            rpt.status      = ST_SYMBOL;
            rpt.symbol      = '0;
            rpt.code_length = '0;
            rpt.table_bytes = '0;

            // Code bit: extend the code by one bit and try the next length
            if (kind == KIND_BIT)
            begin
                if (!have_table)
                begin
                    rpt.status = ST_NO_TABLE;
                    return 1'b1;
                end
                n    = bits_in + 1;
                code = ((accum << 1) | data[0]) & 32'hFFFF;
                cnt  = len_count[n - 1];
                if (code >= first_code && code - first_code < cnt)
                begin
                    pos             = sym_base + (code - first_code);
                    rpt.symbol      = (pos < MAX_SYMBOLS_DEF) ? sym_mem[pos] : '0;
                    rpt.code_length = LEN_W'(n);
                    clear_partial();
                    return 1'b1;
                end
                if (n >= longest || n >= MAX_CODE_LEN_DEF)
                begin
                    rpt.status      = ST_INVALID;
                    rpt.code_length = LEN_W'(n);
                    clear_partial();
                    return 1'b1;
                end
                sym_base   = (sym_base + cnt) & 32'h1FF;
                first_code = ((first_code + cnt) << 1) & 32'h1FFFF;
                accum      = code;
                bits_in    = n;
                return 1'b0;
            end

            // Table byte: restart on first, drop strays
            if (start)
            begin
                load_pos   = 0;
                code_total = 0;
                longest    = 0;
                have_table = 1'b0;
                clear_partial();
            end
            else if (load_pos == 0)
                return 1'b0;

            // Count bytes, then validate the length profile after the last one
            if (load_pos < MAX_CODE_LEN_DEF)
            begin
                len_count[load_pos] = data;
                code_total          = code_total + data;
                if (code_total > 511)
                    code_total = 511;
                if (data != 0)
                    longest = load_pos + 1;
                load_pos++;
                if (load_pos < MAX_CODE_LEN_DEF)
                    return 1'b0;
                if (code_total > MAX_SYMBOLS_DEF)
                begin
                    load_pos   = 0;
                    rpt.status = ST_TOO_MANY;
                    return 1'b1;
                end
                room = 2;
                for (l = 0; l < MAX_CODE_LEN_DEF; l++)
                begin
                    if (len_count[l] > room)
                    begin
                        load_pos   = 0;
                        rpt.status = ST_OVERSUB;
                        return 1'b1;
                    end
                    room = room - len_count[l];
                    if (l < MAX_CODE_LEN_DEF - 1)
                        room = room << 1;
                end
                if (code_total == 0)
                begin
                    load_pos        = 0;
                    have_table      = 1'b1;
                    rpt.status      = ST_LOADED;
                    rpt.table_bytes = TB_W'(MAX_CODE_LEN_DEF);
                    return 1'b1;
                end
                return 1'b0;
            end

            // Symbol bytes in canonical order
            pos = load_pos - MAX_CODE_LEN_DEF;
            if (pos < MAX_SYMBOLS_DEF)
                sym_mem[pos] = data;
            load_pos++;
            if (pos + 1 >= code_total)
            begin
                rpt.status      = ST_LOADED;
                rpt.table_bytes = TB_W'(load_pos);
                load_pos        = 0;
                have_table      = 1'b1;
                clear_partial();
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Queue what an accepted item yields; return 0 for a stray table byte
        function bit note_item(bit kind, logic [DATA_W-1:0] data, bit start);
            huff_report_t rpt;
            bit           stray;
            stray = (kind == KIND_TABLE) && !start && load_pos == 0;
            if (predict_report(kind, data, start, rpt))
                due_reports.push_back(rpt);
            return !stray;
        endfunction

        task report_mismatch(string msg);
            error_count++;
            if (error_count <= MAX_PRINTS)
                $display("%0t: mismatch: %s", $time, msg);
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] symbol,
                          logic [LEN_W-1:0] code_length, logic [TB_W-1:0] table_bytes);
            huff_report_t want;
            if (due_reports.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending, status %0d", status));
                return;
            end
            want = due_reports.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", status, want.status));
            if (symbol !== want.symbol)
                report_mismatch($sformatf("symbol %0h, want %0h", symbol, want.symbol));
            if (code_length !== want.code_length)
                report_mismatch($sformatf("code_length %0d, want %0d",
                                          code_length, want.code_length));
            if (table_bytes !== want.table_bytes)
                report_mismatch($sformatf("table_bytes %0d, want %0d",
                                          table_bytes, want.table_bytes));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    chtd_in_if  items_if ();
    chtd_out_if results_if ();

    canonical_huffman_table_decoder_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    huffman_scoreboard sb = new();
    int unsigned       useful_items = 0;
    int unsigned       burst_left = 0;
    bit                hold_request = 1'b0;
    int unsigned       plan_counts [MAX_CODE_LEN_DEF];
    logic [DATA_W-1:0] plan_symbols [$];

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1)
            sb.check_result(results_if.status, results_if.symbol,
                            results_if.code_length, results_if.table_bytes);
    end

    // Drive results.ready: random modes, plus a long hold-off on request
    initial
    begin : result_sink
        sink_mode_t  mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned phase;
        results_if.ready = 1'b0;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            phase++;
            if (hold_left != 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_OPEN:   results_if.ready <= 1'b1;
                    SINK_MOSTLY: results_if.ready <= ($urandom_range(0, 3) != 0);
                    SINK_SPARSE: results_if.ready <= ($urandom_range(0, 3) == 0);
                    default:     results_if.ready <= (phase % 3 == 0);
                endcase
            end
        end
    end

    // Offer one item at a falling edge and hold it until its transfer;
    // open a random gap at the start of each burst
    task automatic send_item(input bit kind, input logic [DATA_W-1:0] data, input bit start);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                items_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        items_if.valid <= 1'b1;
        items_if.kind  <= kind;
        items_if.data  <= data;
        items_if.first <= start;
        @(posedge clk);
        while (items_if.ready !== 1'b1)
            @(posedge clk);
        if (sb.note_item(kind, data, start))
            useful_items++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every expected result has arrived
    task automatic pause_until_drained();
        items_if.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (sb.pending() != 0);
    endtask

    // Build a complete length profile by splitting codes one at a time
    function automatic void plan_complete(int unsigned n_codes, int unsigned max_len);
        int unsigned total;
        int unsigned tries;
        int unsigned l;
        foreach (plan_counts[i])
            plan_counts[i] = 0;
        plan_counts[0] = 2;
        total = 2;
        tries = 0;
        while (total < n_codes && tries < 4000 && max_len > 1)
        begin
            l = $urandom_range(0, max_len - 2);
            if (plan_counts[l] != 0 && plan_counts[l + 1] <= 253)
            begin
                plan_counts[l]--;
                plan_counts[l + 1] += 2;
                total++;
            end
            tries++;
        end
    endfunction

    // Send the planned counts, then symbols while the load goes on;
    // stop_after cuts the load short, zero means send it all
    task automatic load_planned(input bit noisy, input int unsigned stop_after);
        int unsigned       sent;
        int unsigned       l;
        logic [DATA_W-1:0] sym;
        sent = 0;
        l    = 0;
        while (l < MAX_CODE_LEN_DEF && (stop_after == 0 || sent < stop_after))
        begin
            if (noisy && $urandom_range(0, 5) == 0)
                send_item(KIND_BIT, 8'($urandom), 1'($urandom_range(0, 1)));
            send_item(KIND_TABLE, 8'(plan_counts[l]), l == 0);
            l++;
            sent++;
        end
        while (sb.loading() && (stop_after == 0 || sent < stop_after))
        begin
            if (noisy && $urandom_range(0, 5) == 0)
                send_item(KIND_BIT, 8'($urandom), 1'($urandom_range(0, 1)));
            if (plan_symbols.size() != 0)
                sym = plan_symbols.pop_front();
            else if ($urandom_range(0, 7) == 0)
                sym = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                sym = 8'($urandom);
            send_item(KIND_TABLE, sym, 1'b0);
            sent++;
        end
    endtask

    // Send code bits with a given share of ones, sprinkled with stray table bytes
    task automatic decode_run(input int unsigned n, input int unsigned ones_weight);
        int unsigned       i;
        logic [DATA_W-1:0] d;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 31) == 0)
                send_item(KIND_TABLE, 8'($urandom), 1'b0);
            d    = 8'($urandom);
            d[0] = ($urandom_range(0, 15) < ones_weight);
            send_item(KIND_BIT, d, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : stimulus
        int unsigned episode;
        int unsigned pick;
        int unsigned drop;
        int unsigned tries;
        int unsigned l;
        items_if.valid = 1'b0;
        items_if.kind  = KIND_TABLE;
        items_if.data  = '0;
        items_if.first = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Bit with no table, then a stray table byte
        send_item(KIND_BIT, 8'h01, 1'b1);
        send_item(KIND_TABLE, 8'hFF, 1'b0);

        // Empty table, then a bit that matches nothing
        foreach (plan_counts[i])
            plan_counts[i] = 0;
        load_planned(1'b0, 0);
        send_item(KIND_BIT, 8'hFE, 1'b0);

        // Two one-bit codes carrying the extreme symbols
        plan_counts[0] = 2;
        plan_symbols.push_back(8'h00);
        plan_symbols.push_back(8'hFF);
        load_planned(1'b0, 0);
        send_item(KIND_BIT, 8'h00, 1'b0);
        send_item(KIND_BIT, 8'h01, 1'b0);

        // Oversubscribed: three codes of length one; then a bit finds no table
        plan_counts[0] = 3;
        load_planned(1'b0, 0);
        send_item(KIND_BIT, 8'h01, 1'b0);

        // Too many codes, with the running total saturating
        foreach (plan_counts[i])
            plan_counts[i] = 255;
        load_planned(1'b0, 0);

        // Restart in the middle of a load, then decode a few bits
        plan_complete(4, 3);
        load_planned(1'b0, 5);
        load_planned(1'b0, 0);
        decode_run(8, 8);

        // Random episodes until enough items have been consumed
        useful_items = 0;
        episode      = 0;
        while (useful_items < RANDOM_ITEMS)
        begin
            pick = (episode < 3) ? episode : $urandom_range(3, 99);
            if (pick == 0)
            begin
                // Long receiver hold-off while bits keep coming
                plan_complete($urandom_range(3, 10), 5);
                load_planned(1'b0, 0);
                hold_request = 1'b1;
                decode_run(80, 8);
            end
            else if (pick == 1)
            begin
                // Largest table
                plan_complete(MAX_SYMBOLS_DEF, MAX_CODE_LEN_DEF);
                load_planned(1'b0, 0);
                decode_run(120, 8);
            end
            else if (pick == 2 || pick >= 92)
            begin
                // One code per length down to the longest, fed mostly ones
                foreach (plan_counts[i])
                    plan_counts[i] = 1;
                plan_counts[MAX_CODE_LEN_DEF - 1] = $urandom_range(1, 2);
                load_planned(1'($urandom_range(0, 1)), 0);
                decode_run($urandom_range(30, 60), 15);
            end
            else if (pick < 50)
            begin
                // Ordinary table, sometimes with codes removed
                if ($urandom_range(0, 9) == 0)
                    plan_complete($urandom_range(20, 120), $urandom_range(2, 16));
                else
                    plan_complete($urandom_range(2, 12), $urandom_range(2, 16));
                if ($urandom_range(0, 2) == 0)
                begin
                    drop = $urandom_range(1, 3);
                    for (tries = 0; tries < 64 && drop != 0; tries++)
                    begin
                        l = $urandom_range(0, MAX_CODE_LEN_DEF - 1);
                        if (plan_counts[l] != 0)
                        begin
                            plan_counts[l]--;
                            drop--;
                        end
                    end
                end
                load_planned($urandom_range(0, 3) == 0, 0);
                if ($urandom_range(0, 19) == 0)
                    hold_request = 1'b1;
                decode_run($urandom_range(10, 60), 8);
            end
            else if (pick < 58)
            begin
                // Too many codes, or right at the symbol limit
                if ($urandom_range(0, 1) == 0)
                begin
                    foreach (plan_counts[i])
                        plan_counts[i] = $urandom_range(0, 255);
                end
                else
                begin
                    foreach (plan_counts[i])
                        plan_counts[i] = 0;
                    plan_counts[7] = 255;
                    plan_counts[8] = $urandom_range(1, 2);
                end
                load_planned($urandom_range(0, 3) == 0, 0);
                decode_run($urandom_range(2, 6), 8);
            end
            else if (pick < 66)
            begin
                // Complete profile plus one code
                plan_complete($urandom_range(2, 12), $urandom_range(2, 10));
                l = $urandom_range(0, 9);
                plan_counts[l]++;
                load_planned(1'b0, 0);
                decode_run($urandom_range(2, 6), 8);
            end
            else if (pick < 78)
            begin
                // Cut a load short and start over
                plan_complete($urandom_range(2, 10), 8);
                load_planned(1'b1, $urandom_range(1, 22));
                plan_complete($urandom_range(2, 10), $urandom_range(2, 12));
                load_planned(1'b0, 0);
                decode_run($urandom_range(10, 40), 8);
            end
            else
            begin
                // Unstructured items
                repeat ($urandom_range(5, 25))
                    send_item(1'($urandom_range(0, 1)), 8'($urandom),
                              $urandom_range(0, 7) == 0);
            end
            episode++;
            if (episode % 6 == 0)
                pause_until_drained();
        end

        pause_until_drained();
        repeat (4) @(negedge clk);
        if (sb.error_count == 0)
            $display("tb_canonical_huffman_table_decoder_top: done, clean");
        else
            $display("tb_canonical_huffman_table_decoder_top: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("tb_canonical_huffman_table_decoder_top: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/chtd_pkg.sv
hdl/chtd_channels.sv
hdl/chtd_loader.sv
hdl/canonical_huffman_table_decoder_top.sv
hdl/chtd_checker.sv
test/tb_canonical_huffman_table_decoder_top.sv
